/* src/mtcd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtcd_pkg
// shared types, sizes and register codes of the multi-tap chorus delay unit
// ----------------------------------------------------------------------------
package mtcd_pkg;

    localparam int HISTORY_DEPTH = 8192;
    localparam int TAP_COUNT     = 6;

    localparam int SAMPLE_W   = 16;
    localparam int SPACING_W  = 11;
    localparam int NUM_GAINS  = 6;
    localparam int ADDR_W     = $clog2(HISTORY_DEPTH);
    localparam int GAIN_IDX_W = $clog2(NUM_GAINS);
    localparam int TAP_IDX_W  = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
    localparam int PROD_W     = 2 * SAMPLE_W;
    localparam int SHIFT_W    = PROD_W - 15;
    localparam int ACC_W      = SHIFT_W + $clog2(TAP_COUNT + 1);
    localparam int WIDE_W     = 17;
    localparam int CFG_IDX_W  = 3;

    localparam logic signed [ACC_W-1:0] SAMPLE_MAX = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] SAMPLE_MIN = -ACC_W'(32768);

    localparam logic [SPACING_W-1:0] SPACING_RESET = SPACING_W'(400);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TAP_GAIN_ONE,
        REG_TAP_GAIN_TWO,
        REG_TAP_GAIN_THREE,
        REG_TAP_GAIN_FOUR,
        REG_TAP_GAIN_FIVE,
        REG_TAP_GAIN_SIX,
        REG_TAP_SPACING
    } t_reg_idx;

    typedef struct packed {
        logic [NUM_GAINS-1:0][SAMPLE_W-1:0] gain;
        logic [SPACING_W-1:0]               spacing;
    } t_cfg;

    function automatic logic [SAMPLE_W-1:0] gain_reset(input int idx);
        logic [SAMPLE_W-1:0] g;
        case (idx)
            0:       g = SAMPLE_W'(13107);
            1:       g = SAMPLE_W'(2327);
            2:       g = SAMPLE_W'(6914);
            3:       g = SAMPLE_W'(15008);
            4:       g = SAMPLE_W'(12976);
            5:       g = SAMPLE_W'(15696);
            default: g = '0;
        endcase
        return g;
    endfunction

    // taps past the register set have a fixed gain of zero
    function automatic logic signed [SAMPLE_W-1:0] tap_gain(
        input t_cfg                 c,
        input logic [TAP_IDX_W-1:0] tap
    );
        logic signed [SAMPLE_W-1:0] g;
        if (32'(tap) < NUM_GAINS) begin
            g = $signed(c.gain[GAIN_IDX_W'(tap)]);
        end else begin
            g = '0;
        end
        return g;
    endfunction

endpackage

/* src/mtcd_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtcd_regs
// configuration register file: tap gains and tap spacing
// ----------------------------------------------------------------------------
module mtcd_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [mtcd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mtcd_pkg::SAMPLE_W-1:0]  i_cfg_data,
    output mtcd_pkg::t_cfg                 o_cfg
);
    import mtcd_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_GAINS; k++) begin
                r_cfg.gain[k] <= gain_reset(k);
            end
            r_cfg.spacing <= SPACING_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_reg_idx'(i_cfg_index))
                REG_TAP_GAIN_ONE, REG_TAP_GAIN_TWO, REG_TAP_GAIN_THREE,
                REG_TAP_GAIN_FOUR, REG_TAP_GAIN_FIVE, REG_TAP_GAIN_SIX: begin
                    r_cfg.gain[GAIN_IDX_W'(i_cfg_index)] <= i_cfg_data;
                end
                REG_TAP_SPACING: begin
                    r_cfg.spacing <= i_cfg_data[SPACING_W-1:0];
                end
                default: begin
                    // unused index, word dropped
                end
            endcase
        end
    end

endmodule

/* src/multi_tap_chorus_delay_unit.sv */
`timescale 1ns / 1ps
// flow: the six tap reads go one per cycle through the single read port of the
//   history memory, then multiply and accumulate drain; the output word is registered
//   once the output slot is free, and no new input word is taken before then
// reset: synchronous; a clearing pass zeroes all 8192 history words, input stalled
//   meanwhile, configuration writes taken throughout
// ----------------------------------------------------------------------------
// multi_tap_chorus_delay_unit
// writes each sample into a circular history, sums six gained taps onto it
// ----------------------------------------------------------------------------
module multi_tap_chorus_delay_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic signed [mtcd_pkg::SAMPLE_W-1:0]  i_sample_in,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [mtcd_pkg::SAMPLE_W-1:0]  o_sample_out,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [mtcd_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [mtcd_pkg::SAMPLE_W-1:0]         i_cfg_data
);
    import mtcd_pkg::*;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_ISSUE,
        S_DRAIN
    } t_state;

    t_cfg cfg;

    mtcd_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    t_state                      r_state;
    logic [ADDR_W-1:0]           r_clr_addr;
    logic [ADDR_W-1:0]           r_wp;
    logic [ADDR_W-1:0]           r_delay;
    logic [TAP_IDX_W-1:0]        r_iss_cnt;
    logic                        r_rd_vld;
    logic [TAP_IDX_W-1:0]        r_rd_tap;
    logic                        r_prod_vld;
    logic signed [PROD_W-1:0]    r_prod;
    logic signed [ACC_W-1:0]     r_acc;
    logic                        r_out_vld;
    logic signed [SAMPLE_W-1:0]  r_out_data;

    logic signed [SAMPLE_W-1:0]  mem [HISTORY_DEPTH];
    logic signed [SAMPLE_W-1:0]  r_mem_q;

    logic                        in_acc;
    logic                        out_free;
    logic                        mem_we;
    logic [ADDR_W-1:0]           mem_wa;
    logic signed [SAMPLE_W-1:0]  mem_wd;
    logic                        rd_en;
    logic [ADDR_W-1:0]           rd_addr;
    logic [WIDE_W-1:0]           delay_sum;
    logic signed [ACC_W-1:0]     acc_sat_in;
    logic signed [SAMPLE_W-1:0]  sat_val;

    assign o_in_stall   = (r_state != S_IDLE);
    assign in_acc       = i_in_valid && !o_in_stall;
    assign out_free     = !r_out_vld || !i_out_stall;
    assign o_out_valid  = r_out_vld;
    assign o_sample_out = r_out_data;

    // the sample goes in at the accept edge, so a zero-delay tap sees it
    assign mem_we = (r_state == S_CLEAR) || in_acc;
    assign mem_wa = (r_state == S_CLEAR) ? r_clr_addr : r_wp;
    assign mem_wd = (r_state == S_CLEAR) ? '0 : i_sample_in;

    assign rd_en     = (r_state == S_ISSUE);
    assign rd_addr   = r_wp - r_delay;
    assign delay_sum = WIDE_W'(r_delay) + WIDE_W'(cfg.spacing);

    assign acc_sat_in = r_acc;
    always_comb begin
        if (acc_sat_in > SAMPLE_MAX) begin
            sat_val = SAMPLE_MAX[SAMPLE_W-1:0];
        end else if (acc_sat_in < SAMPLE_MIN) begin
            sat_val = SAMPLE_MIN[SAMPLE_W-1:0];
        end else begin
            sat_val = acc_sat_in[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (rd_en) begin
            r_mem_q <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_wp       <= '0;
            r_iss_cnt  <= '0;
            r_rd_vld   <= 1'b0;
            r_prod_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_rd_vld   <= rd_en;
            r_rd_tap   <= r_iss_cnt;
            r_prod_vld <= r_rd_vld;
            if (r_rd_vld) begin
                r_prod <= r_mem_q * tap_gain(cfg, r_rd_tap);
            end
            if (r_prod_vld) begin
                // arithmetic shift is the floor of the q15 product
                r_acc <= r_acc + ACC_W'(r_prod >>> 15);
            end
            if (r_out_vld && !i_out_stall) begin
                r_out_vld <= 1'b0;
            end

            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == ADDR_W'(HISTORY_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        r_acc     <= ACC_W'(i_sample_in);
                        r_delay   <= delay_sum[ADDR_W-1:0] - r_delay + ADDR_W'(0);
                        r_iss_cnt <= '0;
                        r_state   <= S_ISSUE;
                    end
                end
                S_ISSUE: begin
                    r_delay   <= delay_sum[ADDR_W-1:0];
                    r_iss_cnt <= r_iss_cnt + 1'b1;
                    if (r_iss_cnt == TAP_IDX_W'(TAP_COUNT - 1)) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (!r_rd_vld && !r_prod_vld && out_free) begin
                        r_out_vld  <= 1'b1;
                        r_out_data <= sat_val;
                        r_wp       <= r_wp + 1'b1;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* src/mtcd_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtcd_checker
// port-level checks of the chorus delay unit over time
// ----------------------------------------------------------------------------
module mtcd_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_in_valid,
    input logic                                  o_in_stall,
    input logic signed [mtcd_pkg::SAMPLE_W-1:0]  i_sample_in,
    input logic                                  o_out_valid,
    input logic                                  i_out_stall,
    input logic signed [mtcd_pkg::SAMPLE_W-1:0]  o_sample_out,
    input logic                                  i_cfg_valid,
    input logic                                  o_cfg_ready,
    input logic [mtcd_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input logic [mtcd_pkg::SAMPLE_W-1:0]         i_cfg_data
);

    // the clearing pass keeps the input stalled right after reset
    a_clear_stall: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("input not stalled after reset");

    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output word valid after reset");

    // one word in flight: the input stays stalled after each accepted word
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall ##1 o_in_stall)
        else $error("input taken again too soon");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_sample_out)))
        else $error("stalled output word changed");

endmodule

bind multi_tap_chorus_delay_unit mtcd_checker u_mtcd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .i_sample_in  (i_sample_in),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_sample_out (o_sample_out),
    .i_cfg_valid  (i_cfg_valid),
    .o_cfg_ready  (o_cfg_ready),
    .i_cfg_index  (i_cfg_index),
    .i_cfg_data   (i_cfg_data)
);
